/* hw/rtl/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// mbrc_pkg: shared types and constants of the MBR partition table checker
// Entry layout, classification codes, status codes and the job record that
// passes from the byte capture front end to the table checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

   // Geometry of sector zero
   localparam int ENTRY_COUNT  = 4;
   localparam int SECTOR_BYTES = 512;
   localparam int EIDX_W       = (ENTRY_COUNT > 2) ? 2 : 1;
   localparam int OFFSET_W     = 9;
   localparam int ENTRY_BYTES  = 16;

   localparam logic [OFFSET_W-1:0] TABLE_BASE = 9'd446;
   localparam logic [OFFSET_W-1:0] TABLE_END  = OFFSET_W'(446 + ENTRY_BYTES * ENTRY_COUNT);
   localparam logic [OFFSET_W-1:0] SIG_OFFSET = 9'd510;
   localparam logic [OFFSET_W-1:0] LAST_OFFSET = OFFSET_W'(SECTOR_BYTES - 1);

   // Byte positions inside one 16-byte entry
   localparam logic [3:0] FLD_BOOT     = 4'd0;
   localparam logic [3:0] FLD_TYPE     = 4'd4;
   localparam logic [3:0] FLD_START_LO = 4'd8;
   localparam logic [3:0] FLD_START_HI = 4'd11;
   localparam logic [3:0] FLD_LEN_LO   = 4'd12;
   localparam logic [3:0] FLD_LEN_HI   = 4'd15;

   // Marker bytes
   localparam logic [7:0] SIG_BYTE0 = 8'h55;
   localparam logic [7:0] SIG_BYTE1 = 8'haa;
   localparam logic [7:0] BOOT_FLAG = 8'h80;

   // Partition type bytes
   localparam logic [7:0] TYPE_EMPTY     = 8'h00;
   localparam logic [7:0] TYPE_FAT16_SM  = 8'h04;
   localparam logic [7:0] TYPE_FAT16     = 8'h06;
   localparam logic [7:0] TYPE_FAT32_CHS = 8'h0b;
   localparam logic [7:0] TYPE_FAT32_LBA = 8'h0c;
   localparam logic [7:0] TYPE_FAT16_LBA = 8'h0e;
   localparam logic [7:0] TYPE_LINUX     = 8'h83;
   localparam logic [7:0] TYPE_EXT_CHS   = 8'h05;
   localparam logic [7:0] TYPE_EXT_LBA   = 8'h0f;
   localparam logic [7:0] TYPE_GPT_PROT  = 8'hee;

   // Kind classes
   localparam logic [2:0] KIND_EMPTY    = 3'd0;
   localparam logic [2:0] KIND_FAT      = 3'd1;
   localparam logic [2:0] KIND_LINUX    = 3'd2;
   localparam logic [2:0] KIND_EXTENDED = 3'd3;
   localparam logic [2:0] KIND_GPT      = 3'd4;
   localparam logic [2:0] KIND_OTHER    = 3'd5;

   // Table status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CORRUPT = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;
   localparam int COUNT_W    = 48;
   localparam int SIZE_W     = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECTOR_SIZE  = 1'd1;
   localparam logic [SIZE_W-1:0]    SIZE_RESET       = SIZE_W'(SECTOR_BYTES);

   // Job queue
   localparam int JOBQ_DEPTH = 2;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   localparam int END_W = 33;

   typedef struct packed {
      logic [7:0]  ptype;
      logic        boot;
      logic [31:0] start;
      logic [31:0] len;
   } part_entry_type;

   typedef struct packed {
      part_entry_type [ENTRY_COUNT-1:0] entries;
      logic                             sig_ok;
      logic                             size_ok;
      logic [COUNT_W-1:0]               count;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jobq_stat_type;

   typedef struct packed {
      logic [1:0]  entry_index;
      logic [7:0]  part_type;
      logic [2:0]  part_kind;
      logic        bootable;
      logic [31:0] start_sector;
      logic [31:0] length_sectors;
      logic [1:0]  table_status;
      logic        last_entry;
   } rsp_type;

   // Map a raw type byte onto its kind class
   function automatic logic [2:0] kind_of(input logic [7:0] ptype);
      logic [2:0] kind;
      case (ptype)
         TYPE_EMPTY: kind = KIND_EMPTY;
         TYPE_FAT16_SM, TYPE_FAT16, TYPE_FAT32_CHS, TYPE_FAT32_LBA, TYPE_FAT16_LBA:
            kind = KIND_FAT;
         TYPE_LINUX: kind = KIND_LINUX;
         TYPE_EXT_CHS, TYPE_EXT_LBA: kind = KIND_EXTENDED;
         TYPE_GPT_PROT: kind = KIND_GPT;
         default: kind = KIND_OTHER;
      endcase
      return kind;
   endfunction

endpackage

/* hw/rtl/mbrc_front.sv */
// ----------------------------------------------------------------------------
// mbrc_front: byte capture front end
// Tracks the byte offset in sector zero, assembles the four table entries and
// the signature, holds the device registers and hands a job to the queue on
// the last byte of the sector.
// ----------------------------------------------------------------------------
module mbrc_front import mbrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_sector_byte,
   output logic                  req_full,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  jobq_stat_type         jobq_stat,
   output logic                  job_push,
   output job_type               job_data
);

   logic [OFFSET_W-1:0]              offset_ff, offset_in;
   logic                             sig_lo_ff, sig_lo_in;
   part_entry_type [ENTRY_COUNT-1:0] ent_ff, ent_in;
   logic [COUNT_W-1:0]               count_ff, count_in;
   logic [SIZE_W-1:0]                size_ff, size_in;

   logic                        accept;
   logic                        in_table;
   logic [OFFSET_W-1:0]         rel;
   logic [EIDX_W-1:0]           eidx;
   logic [3:0]                  field;

   // Stall only the last byte, and only while no job slot is free
   assign req_full = (offset_ff == LAST_OFFSET) && jobq_stat.full;
   assign accept   = req_push && !req_full;

   // Decode the position of the current byte
   always_comb begin
      rel      = offset_ff - TABLE_BASE;
      in_table = (offset_ff >= TABLE_BASE) && (offset_ff < TABLE_END);
      eidx     = rel[EIDX_W+3:4];
      field    = rel[3:0];
   end

   // Assemble entries; start and length shift in little-endian
   always_comb begin
      ent_in = ent_ff;
      if (accept && in_table) begin
         if (field == FLD_BOOT) begin
            ent_in[eidx].boot = (req_sector_byte == BOOT_FLAG);
         end else if (field == FLD_TYPE) begin
            ent_in[eidx].ptype = req_sector_byte;
         end else if (field inside {[FLD_START_LO:FLD_START_HI]}) begin
            ent_in[eidx].start = {req_sector_byte, ent_ff[eidx].start[31:8]};
         end else if (field inside {[FLD_LEN_LO:FLD_LEN_HI]}) begin
            ent_in[eidx].len = {req_sector_byte, ent_ff[eidx].len[31:8]};
         end
      end
   end

   // Advance the offset and catch the first signature byte
   always_comb begin
      offset_in = offset_ff;
      sig_lo_in = sig_lo_ff;
      if (accept) begin
         offset_in = (offset_ff == LAST_OFFSET) ? '0 : offset_ff + 1'b1;
         if (offset_ff == SIG_OFFSET) begin
            sig_lo_in = (req_sector_byte == SIG_BYTE0);
         end
      end
   end

   // Register writes
   always_comb begin
      count_in = count_ff;
      size_in  = size_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SECTOR_COUNT: count_in = csr_wdata[COUNT_W-1:0];
            CSR_SECTOR_SIZE:  size_in  = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Hand over the finished sector
   always_comb begin
      job_push         = accept && (offset_ff == LAST_OFFSET);
      job_data.entries = ent_ff;
      job_data.sig_ok  = sig_lo_ff && (req_sector_byte == SIG_BYTE1);
      job_data.size_ok = (size_ff >= SIZE_W'(SECTOR_BYTES));
      job_data.count   = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sig_lo_ff <= 1'b0;
         count_ff  <= '0;
         size_ff   <= SIZE_RESET;
      end else begin
         offset_ff <= offset_in;
         sig_lo_ff <= sig_lo_in;
         count_ff  <= count_in;
         size_ff   <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      job_push |-> !jobq_stat.full)
      else $error("job pushed into a full queue");

   a_offset_wraps : assert property (@(posedge clock) disable iff (reset)
      (accept && (offset_ff == LAST_OFFSET)) |=> (offset_ff == '0))
      else $error("byte offset did not wrap after the last byte");

endmodule

/* hw/rtl/mbrc_job_queue.sv */
// ----------------------------------------------------------------------------
// mbrc_job_queue: short queue of captured sectors
// Holds finished partition tables between the front end and the checker so
// that either side can stall on its own.
// ----------------------------------------------------------------------------
module mbrc_job_queue import mbrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       push_data,
   input  logic          pop,
   output job_type       head,
   output jobq_stat_type stat
);

   job_type               slots_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOBQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOBQ_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign stat.full  = (count_ff == JOBQ_CNT_W'(JOBQ_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      do_push   = push && !stat.full;
      do_pop    = pop && !stat.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= JOBQ_CNT_W'(JOBQ_DEPTH))
      else $error("job queue occupancy above its depth");

endmodule

/* hw/rtl/mbrc_back.sv */
// ----------------------------------------------------------------------------
// mbrc_back: table checker and result emitter
// Takes one job, checks bounds and start of each entry, checks every pair of
// entries for overlap, then emits one result per entry through an output
// register. Entries sit in a rotating row so slot 0 is the one in work.
// ----------------------------------------------------------------------------
module mbrc_back import mbrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  jobq_stat_type jobq_stat,
   input  job_type       job_head,
   output logic          job_pop,
   input  logic          rsp_pop,
   output logic          rsp_empty,
   output rsp_type       rsp
);

   typedef struct packed {
      part_entry_type   ent;
      logic [END_W-1:0] fin;
   } slot_type;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_PAIR  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic [EIDX_W-1:0] LAST_IDX = EIDX_W'(ENTRY_COUNT - 1);

   logic [1:0]                 state_ff, state_in;
   slot_type [ENTRY_COUNT-1:0] slot_ff, slot_in;
   logic                       sig_ok_ff, sig_ok_in;
   logic                       size_ok_ff, size_ok_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       bad_ff, bad_in;
   logic [EIDX_W-1:0]          row_ff, row_in;
   logic [EIDX_W-1:0]          col_ff, col_in;
   logic                       out_valid_ff, out_valid_in;
   rsp_type                    out_ff, out_in;

   slot_type [ENTRY_COUNT-1:0] slot_upd, slot_rot;
   slot_type                   s0, sk;
   logic                       used0, usedk;
   logic [END_W-1:0]           end0;
   logic [EIDX_W-1:0]          lim;
   logic                       do_cmp;
   logic                       overlap;
   logic                       out_load;
   logic [1:0]                 status;

   // Slot 0 view, its end sector and the pair candidate
   always_comb begin
      s0      = slot_ff[0];
      sk      = slot_ff[col_ff];
      used0   = (s0.ent.len != '0);
      usedk   = (sk.ent.len != '0);
      end0    = END_W'(s0.ent.start) + END_W'(s0.ent.len);
      lim     = LAST_IDX - row_ff;
      do_cmp  = (col_ff <= lim);
      overlap = used0 && usedk && (END_W'(s0.ent.start) < sk.fin)
                && (END_W'(sk.ent.start) < s0.fin);
      status  = !size_ok_ff ? STATUS_INVALID
              : (sig_ok_ff && !bad_ff) ? STATUS_OK : STATUS_CORRUPT;
   end

   // Rotate the row by one slot, slot 0 moving to the end
   always_comb begin
      slot_upd = slot_ff;
      if (state_ff == ST_CHECK) begin
         slot_upd[0].fin = end0;
      end
      for (int k = 0; k < ENTRY_COUNT; k++) begin
         slot_rot[k] = slot_upd[(k + 1) % ENTRY_COUNT];
      end
   end

   // Sequence one job
   always_comb begin
      state_in   = state_ff;
      slot_in    = slot_ff;
      sig_ok_in  = sig_ok_ff;
      size_ok_in = size_ok_ff;
      count_in   = count_ff;
      bad_in     = bad_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      job_pop    = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!jobq_stat.empty) begin
               job_pop = 1'b1;
               for (int k = 0; k < ENTRY_COUNT; k++) begin
                  slot_in[k].ent = job_head.entries[k];
                  slot_in[k].fin = '0;
               end
               sig_ok_in  = job_head.sig_ok;
               size_ok_in = job_head.size_ok;
               count_in   = job_head.count;
               bad_in     = 1'b0;
               col_in     = '0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // bound and start-sector check of one used entry
            if (used0 && ((COUNT_W'(end0) > count_ff) || (s0.ent.start == '0))) begin
               bad_in = 1'b1;
            end
            slot_in = slot_rot;
            if (col_ff == LAST_IDX) begin
               row_in   = '0;
               col_in   = EIDX_W'(1);
               state_in = ST_PAIR;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_PAIR: begin
            // slot 0 against the later entries, one pair a cycle
            if (do_cmp && overlap) begin
               bad_in = 1'b1;
            end
            if (col_ff >= lim) begin
               slot_in = slot_rot;
               col_in  = EIDX_W'(1);
               row_in  = row_ff + 1'b1;
               if (row_ff == LAST_IDX) begin
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_EMIT;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_load = 1'b1;
               slot_in  = slot_rot;
               col_in   = col_ff + 1'b1;
               if (col_ff == LAST_IDX) begin
                  col_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Build the result for slot 0; clear it on a non-ok table
   always_comb begin
      out_in                = out_ff;
      out_valid_in          = out_valid_ff;
      if (out_load) begin
         out_valid_in          = 1'b1;
         out_in.entry_index    = 2'(col_ff);
         out_in.table_status   = status;
         out_in.last_entry     = (col_ff == LAST_IDX);
         out_in.part_type      = '0;
         out_in.part_kind      = KIND_EMPTY;
         out_in.bootable       = 1'b0;
         out_in.start_sector   = '0;
         out_in.length_sectors = '0;
         if (status == STATUS_OK) begin
            out_in.part_type = s0.ent.ptype;
            out_in.bootable  = s0.ent.boot;
            if (used0) begin
               out_in.part_kind      = kind_of(s0.ent.ptype);
               out_in.start_sector   = s0.ent.start;
               out_in.length_sectors = s0.ent.len;
            end
         end
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         bad_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         bad_ff       <= bad_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      sig_ok_ff  <= sig_ok_in;
      size_ok_ff <= size_ok_in;
      count_ff   <= count_in;
      out_ff     <= out_in;
   end

   a_pop_only_idle : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == ST_IDLE) && !jobq_stat.empty)
      else $error("job taken while a table is still in work");

   a_last_matches_index : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.last_entry == (out_ff.entry_index == 2'(LAST_IDX))))
      else $error("last entry flag disagrees with entry index");

   a_cleared_on_error : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.table_status != STATUS_OK))
      |-> (out_ff.part_type == '0) && (out_ff.start_sector == '0)
          && (out_ff.length_sectors == '0) && !out_ff.bootable)
      else $error("entry fields not cleared on a failed table");

endmodule

/* hw/rtl/mbr_partition_table_check.sv */
// ----------------------------------------------------------------------------
// mbr_partition_table_check: MBR partition table checker, top level
// Streams sector zero byte by byte, keeps the four partition entries and the
// signature, checks the table and reports one result per entry.
// ----------------------------------------------------------------------------
//
//   channel   ports                      transaction
//   -------   ------------------------   ---------------------------------
//   request   req_push / req_full        one byte of sector zero
//   response  rsp_pop / rsp_empty        one partition entry result
//   csr       csr_we, csr_index          register write, no wait
//
// One byte is taken every cycle; req_full rises only on the last byte of a
// sector while both job queue slots hold tables not yet checked.
// The checker takes a table from the queue, checks each entry in turn, then
// compares the pairs of entries, one pair compare a cycle, then emits one result per
// cycle into the output register as long as rsp_pop keeps up.
// Reset is synchronous; it clears offsets, queues and registers
// (sector count 0, sector size 512). Entry stores are not reset.
// ----------------------------------------------------------------------------
module mbr_partition_table_check import mbrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [7:0]            req_sector_byte,
   output logic                  req_full,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [1:0]            rsp_entry_index,
   output logic [7:0]            rsp_part_type,
   output logic [2:0]            rsp_part_kind,
   output logic                  rsp_bootable,
   output logic [31:0]           rsp_start_sector,
   output logic [31:0]           rsp_length_sectors,
   output logic [1:0]            rsp_table_status,
   output logic                  rsp_last_entry,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   jobq_stat_type jobq_stat;
   logic          job_push;
   logic          job_pop;
   job_type       job_data;
   job_type       job_head;
   rsp_type       rsp;

   // Byte capture
   mbrc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_sector_byte (req_sector_byte),
      .req_full        (req_full),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .jobq_stat       (jobq_stat),
      .job_push        (job_push),
      .job_data        (job_data)
   );

   // Decouple capture from checking
   mbrc_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .head      (job_head),
      .stat      (jobq_stat)
   );

   // Check and emit
   mbrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .jobq_stat (jobq_stat),
      .job_head  (job_head),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_entry_index    = rsp.entry_index;
   assign rsp_part_type      = rsp.part_type;
   assign rsp_part_kind      = rsp.part_kind;
   assign rsp_bootable       = rsp.bootable;
   assign rsp_start_sector   = rsp.start_sector;
   assign rsp_length_sectors = rsp.length_sectors;
   assign rsp_table_status   = rsp.table_status;
   assign rsp_last_entry     = rsp.last_entry;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: MBR partition table checker testbench
// Streams whole boot sectors into the checker, predicts the four entry results
// of each sector and compares them field by field as they are popped. Runs
// directed tables for signatures, bounds, overlaps and sector size first, then
// phases of random tables under random sender bursts and receiver stalls, and a last run with the receiver held.
// ----------------------------------------------------------------------------
module tb_top;
   import mbrc_pkg::*;

   localparam int SETTLE_CYCLES = 32;
   localparam logic [7:0] TYPE_NTFS     = 8'h07;
   localparam logic [7:0] TYPE_ALL_ONES = 8'hff;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic [7:0]            req_sector_byte = '0;
   logic                  req_full;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_empty;
   logic [1:0]            rsp_entry_index;
   logic [7:0]            rsp_part_type;
   logic [2:0]            rsp_part_kind;
   logic                  rsp_bootable;
   logic [31:0]           rsp_start_sector;
   logic [31:0]           rsp_length_sectors;
   logic [1:0]            rsp_table_status;
   logic                  rsp_last_entry;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   mbr_partition_table_check dut (.*);

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Stimulus and expectation stores
   logic [7:0] sector_stream_q[$];
   rsp_type    expected_entries[$];
   int         mismatch_count = 0;

   // Shadow of the checker: registers, position in the sector and kept entries
   logic [COUNT_W-1:0] dev_sectors = '0;
   logic [SIZE_W-1:0]  dev_sector_size = SIZE_W'(SECTOR_BYTES);
   logic [8:0]         sect_offset = '0;
   logic [1:0]         sig_seen = '0;
   logic [7:0]         kept_type  [ENTRY_COUNT];
   logic               kept_boot  [ENTRY_COUNT];
   logic [31:0]        kept_start [ENTRY_COUNT];
   logic [31:0]        kept_len   [ENTRY_COUNT];

   // Table under construction for the next sector
   logic [7:0]  plan_boot  [ENTRY_COUNT];
   logic [7:0]  plan_type  [ENTRY_COUNT];
   logic [31:0] plan_start [ENTRY_COUNT];
   logic [31:0] plan_len   [ENTRY_COUNT];

   // Traffic knobs
   logic       byte_taken = 1'b0;
   bit         send_hold = 1'b0;
   bit         rsp_hold = 1'b0;
   int         gap_pct = 30;
   int         burst_left = 0;
   int         gap_left = 0;
   logic [15:0] pop_pattern = 16'hffff;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ERROR %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Take one accepted byte; on the last byte of the sector queue four results
   task automatic absorb_sector_byte(input logic [7:0] b);
      int unsigned rel, e, f;
      logic [1:0]  status;
      logic [47:0] end_i, end_j;
      rsp_type     want;
      if (sect_offset >= TABLE_BASE && sect_offset < TABLE_END) begin
         rel = sect_offset - TABLE_BASE;
         e = rel / ENTRY_BYTES;
         f = rel % ENTRY_BYTES;
         if (f == FLD_BOOT) kept_boot[e] = (b == BOOT_FLAG);
         else if (f == FLD_TYPE) kept_type[e] = b;
         else if (f >= FLD_START_LO && f <= FLD_START_HI)
            kept_start[e] = {b, kept_start[e][31:8]};
         else if (f >= FLD_LEN_LO) kept_len[e] = {b, kept_len[e][31:8]};
      end
      if (sect_offset == SIG_OFFSET) sig_seen = {1'b0, b == SIG_BYTE0};
      if (sect_offset == LAST_OFFSET && b == SIG_BYTE1) sig_seen[1] = 1'b1;

      if (sect_offset == LAST_OFFSET) begin
         // Sector size first, then signature, bounds, sector zero and overlap
         status = STATUS_OK;
         if (dev_sector_size < SECTOR_BYTES) status = STATUS_INVALID;
         else if (sig_seen != 2'b11) status = STATUS_CORRUPT;
         else begin
            for (int i = 0; i < ENTRY_COUNT; i++) begin
               if (kept_len[i] != 0) begin
                  end_i = 48'(kept_start[i]) + 48'(kept_len[i]);
                  if (end_i > dev_sectors || kept_start[i] == 0) status = STATUS_CORRUPT;
                  for (int j = 0; j < ENTRY_COUNT; j++) begin
                     if (j != i && kept_len[j] != 0) begin
                        end_j = 48'(kept_start[j]) + 48'(kept_len[j]);
                        if (48'(kept_start[i]) < end_j && 48'(kept_start[j]) < end_i)
                           status = STATUS_CORRUPT;
                     end
                  end
               end
            end
         end

         for (int i = 0; i < ENTRY_COUNT; i++) begin
            want = '0;
            want.entry_index = 2'(i);
            if (status == STATUS_OK) begin
               want.part_type = kept_type[i];
               want.bootable  = kept_boot[i];
               if (kept_len[i] != 0) begin
                  want.start_sector   = kept_start[i];
                  want.length_sectors = kept_len[i];
                  case (kept_type[i])
                     TYPE_EMPTY: want.part_kind = KIND_EMPTY;
                     TYPE_FAT16_SM, TYPE_FAT16, TYPE_FAT32_CHS, TYPE_FAT32_LBA,
                     TYPE_FAT16_LBA: want.part_kind = KIND_FAT;
                     TYPE_LINUX: want.part_kind = KIND_LINUX;
                     TYPE_EXT_CHS, TYPE_EXT_LBA: want.part_kind = KIND_EXTENDED;
                     TYPE_GPT_PROT: want.part_kind = KIND_GPT;
                     default: want.part_kind = KIND_OTHER;
                  endcase
               end
            end
            want.table_status = status;
            want.last_entry   = (i == ENTRY_COUNT - 1);
            expected_entries.push_back(want);
         end
      end
      sect_offset = sect_offset + 9'd1;
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin : channel_monitor
      rsp_type want;
      if (reset) begin
         byte_taken <= 1'b0;
      end else begin
         byte_taken <= req_push && !req_full;
         if (req_push && !req_full) absorb_sector_byte(req_sector_byte);
         if (rsp_pop && !rsp_empty) begin
            if (expected_entries.size() == 0) begin
               report_mismatch("result with none expected", rsp_entry_index, 0);
            end else begin
               want = expected_entries.pop_front();
               if (rsp_entry_index !== want.entry_index)
                  report_mismatch("entry_index", rsp_entry_index, want.entry_index);
               if (rsp_part_type !== want.part_type)
                  report_mismatch("part_type", rsp_part_type, want.part_type);
               if (rsp_part_kind !== want.part_kind)
                  report_mismatch("part_kind", rsp_part_kind, want.part_kind);
               if (rsp_bootable !== want.bootable)
                  report_mismatch("bootable", rsp_bootable, want.bootable);
               if (rsp_start_sector !== want.start_sector)
                  report_mismatch("start_sector", rsp_start_sector, want.start_sector);
               if (rsp_length_sectors !== want.length_sectors)
                  report_mismatch("length_sectors", rsp_length_sectors,
                                  want.length_sectors);
               if (rsp_table_status !== want.table_status)
                  report_mismatch("table_status", rsp_table_status, want.table_status);
               if (rsp_last_entry !== want.last_entry)
                  report_mismatch("last_entry", rsp_last_entry, want.last_entry);
            end
         end
      end
   end

   // Drive sector bytes in random bursts; advance the queue on each accepted transaction
   always @(negedge clock) begin : sector_driver
      logic drive;
      drive = 1'b0;
      if (byte_taken) void'(sector_stream_q.pop_front());
      if (!reset && !send_hold && sector_stream_q.size() != 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else begin
            drive = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 64);
               gap_left = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
            end
         end
      end
      req_push <= drive;
      if (drive) req_sector_byte <= sector_stream_q[0];
   end

   // Pop results on a rotating stall pattern
   always @(negedge clock) begin : result_receiver
      pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
      rsp_pop <= !reset && !rsp_hold && pop_pattern[0];
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SECTOR_COUNT) dev_sectors = data[COUNT_W-1:0];
      else dev_sector_size = data[SIZE_W-1:0];
   endtask

   // Wait until every byte is in and every result is out, then let the checker settle
   task automatic drain();
      while (sector_stream_q.size() != 0 || expected_entries.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic clear_plan();
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         plan_boot[i] = '0;
         plan_type[i] = TYPE_EMPTY;
         plan_start[i] = '0;
         plan_len[i] = '0;
      end
   endtask

   task automatic set_slot(input int i, input logic [7:0] boot, input logic [7:0] ptype,
                           input logic [31:0] first_lba, input logic [31:0] lba_count);
      plan_boot[i]  = boot;
      plan_type[i]  = ptype;
      plan_start[i] = first_lba;
      plan_len[i]   = lba_count;
   endtask

   // Lay the planned table into a sector of random filler and queue it
   task automatic queue_sector(input logic [7:0] sig_lo, input logic [7:0] sig_hi);
      logic [7:0]  b;
      int unsigned rel, e, f;
      for (int n = 0; n < SECTOR_BYTES; n++) begin
         b = 8'($urandom_range(0, 255));
         if (n >= TABLE_BASE && n < TABLE_END) begin
            rel = n - TABLE_BASE;
            e = rel / ENTRY_BYTES;
            f = rel % ENTRY_BYTES;
            if (f == FLD_BOOT) b = plan_boot[e];
            else if (f == FLD_TYPE) b = plan_type[e];
            else if (f >= FLD_START_LO && f <= FLD_START_HI)
               b = plan_start[e][8*(f-FLD_START_LO) +: 8];
            else if (f >= FLD_LEN_LO) b = plan_len[e][8*(f-FLD_LEN_LO) +: 8];
         end else if (n == SIG_OFFSET) begin
            b = sig_lo;
         end else if (n == LAST_OFFSET) begin
            b = sig_hi;
         end
         sector_stream_q.push_back(b);
      end
   endtask

   // Mostly well-formed tables with random content; some broken on purpose
   task automatic queue_random_table();
      logic [63:0] cursor;
      logic [7:0]  ptype, boot, sig_lo, sig_hi;
      logic [31:0] first_lba, lba_count;
      int          base, n;
      cursor = $urandom_range(1, 64);
      base = $urandom_range(0, 3);
      for (int k = 0; k < ENTRY_COUNT; k++) begin
         n = (base + k) % ENTRY_COUNT;
         case ($urandom_range(0, 11))
            0: ptype = TYPE_EMPTY;
            1: ptype = TYPE_FAT16_SM;
            2: ptype = TYPE_FAT16;
            3: ptype = TYPE_FAT32_CHS;
            4: ptype = TYPE_FAT32_LBA;
            5: ptype = TYPE_FAT16_LBA;
            6: ptype = TYPE_LINUX;
            7: ptype = TYPE_EXT_CHS;
            8: ptype = TYPE_EXT_LBA;
            9: ptype = TYPE_GPT_PROT;
            default: ptype = 8'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 3) == 0) boot = 8'($urandom_range(0, 255));
         else boot = $urandom_range(0, 1) ? BOOT_FLAG : 8'h00;
         if ($urandom_range(0, 9) < 7) begin
            lba_count = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 5000);
            first_lba = 32'(cursor + $urandom_range(0, 100));
            cursor = 64'(first_lba) + 64'(lba_count);
         end else begin
            lba_count = '0;
            first_lba = $urandom_range(0, 3) ? $urandom : 32'd0;
         end
         set_slot(n, boot, ptype, first_lba, lba_count);
      end
      sig_lo = SIG_BYTE0;
      sig_hi = SIG_BYTE1;
      // Break the table now and then
      case ($urandom_range(0, 11))
         0: begin
            plan_len[0] |= 32'd1;
            plan_len[1] |= 32'd1;
            plan_start[1] = plan_start[0];
         end
         1: plan_start[$urandom_range(0, 3)] = '0;
         2: sig_lo = SIG_BYTE0 ^ (8'h01 << $urandom_range(0, 7));
         3: sig_hi = SIG_BYTE1 ^ (8'h01 << $urandom_range(0, 7));
         4: plan_len[$urandom_range(0, 3)] = 32'hffff_ffff;
         5: begin
            for (int i = 0; i < ENTRY_COUNT; i++) begin
               plan_start[i] = $urandom;
               plan_len[i] = $urandom;
            end
         end
         default: ;
      endcase
      queue_sector(sig_lo, sig_hi);
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      pop_pattern = 16'($urandom_range(0, 65535)) | 16'h0001;

      // Reset values: no sectors on the device, sector size 512
      clear_plan();
      set_slot(0, BOOT_FLAG, TYPE_LINUX, 32'h0000_1234, 32'd0);
      set_slot(2, 8'h00, TYPE_FAT32_LBA, 32'hffff_ffff, 32'd0);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      clear_plan();
      set_slot(3, BOOT_FLAG, TYPE_LINUX, 32'd1, 32'd1);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      drain();

      write_register(CSR_SECTOR_COUNT, '1);
      // Every type class, adjacent entries, odd boot bytes
      clear_plan();
      set_slot(0, BOOT_FLAG, TYPE_FAT16_SM, 32'd1, 32'd100);
      set_slot(1, 8'h00, TYPE_FAT16, 32'd101, 32'd50);
      set_slot(2, 8'h81, TYPE_FAT32_CHS, 32'd151, 32'd1);
      set_slot(3, 8'h7f, TYPE_FAT32_LBA, 32'd152, 32'd7);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      set_slot(0, 8'hff, TYPE_FAT16_LBA, 32'd4000, 32'd10);
      set_slot(1, BOOT_FLAG, TYPE_EXT_CHS, 32'd10, 32'd3990);
      set_slot(2, 8'h00, TYPE_EXT_LBA, 32'd4010, 32'd1000);
      set_slot(3, 8'h80, TYPE_GPT_PROT, 32'd1, 32'd9);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      set_slot(0, 8'h00, TYPE_LINUX, 32'd2048, 32'd2048);
      set_slot(1, 8'h01, TYPE_NTFS, 32'd4096, 32'd4096);
      set_slot(2, BOOT_FLAG, TYPE_ALL_ONES, 32'd8192, 32'd1);
      set_slot(3, 8'h00, TYPE_EMPTY, 32'd8193, 32'd5);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      // Largest start and length
      clear_plan();
      set_slot(1, BOOT_FLAG, TYPE_LINUX, 32'hffff_ffff, 32'hffff_ffff);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      // Overlapping entries
      clear_plan();
      set_slot(0, 8'h00, TYPE_LINUX, 32'd100, 32'd50);
      set_slot(3, 8'h00, TYPE_FAT32_LBA, 32'd149, 32'd10);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      // Used entry at sector zero
      clear_plan();
      set_slot(2, BOOT_FLAG, TYPE_LINUX, 32'd0, 32'd10);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      // Bad signatures
      set_slot(2, BOOT_FLAG, TYPE_LINUX, 32'd63, 32'd10);
      queue_sector(8'h54, SIG_BYTE1);
      queue_sector(SIG_BYTE0, 8'h2a);
      queue_sector(SIG_BYTE1, SIG_BYTE0);
      drain();

      // Entry end against the device size
      write_register(CSR_SECTOR_COUNT, 48'd1000);
      clear_plan();
      set_slot(0, BOOT_FLAG, TYPE_LINUX, 32'd900, 32'd100);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      set_slot(0, BOOT_FLAG, TYPE_LINUX, 32'd901, 32'd100);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      drain();

      // Sector size below 512 wins over a good table and over a bad signature
      write_register(CSR_SECTOR_SIZE, 48'd511);
      set_slot(0, BOOT_FLAG, TYPE_LINUX, 32'd1, 32'd10);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      drain();
      write_register(CSR_SECTOR_SIZE, 48'd0);
      queue_sector(8'h00, 8'hff);
      drain();
      // Only the low 16 bits of the write land in the size register
      write_register(CSR_SECTOR_SIZE, 48'h5a5a_5a5a_ffff);
      queue_sector(SIG_BYTE0, SIG_BYTE1);
      drain();

      // Random phases, each under its own register setting and traffic shape
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_SECTOR_COUNT, 48'h1_0000_0000);
               write_register(CSR_SECTOR_SIZE, 48'd512);
            end
            1: begin
               write_register(CSR_SECTOR_COUNT, 48'($urandom_range(5000, 30000)));
               write_register(CSR_SECTOR_SIZE, 48'd4096);
            end
            2: begin
               write_register(CSR_SECTOR_COUNT, '1);
               write_register(CSR_SECTOR_SIZE, {$urandom, 16'($urandom_range(512, 65535))});
            end
            3: begin
               write_register(CSR_SECTOR_COUNT, {16'($urandom_range(0, 65535)), $urandom});
               write_register(CSR_SECTOR_SIZE, 48'd512);
            end
            default: begin
               write_register(CSR_SECTOR_COUNT, 48'h2_0000_0000);
               write_register(CSR_SECTOR_SIZE, 48'($urandom_range(0, 511)));
            end
         endcase
         gap_pct = (phase == 1) ? 0 : $urandom_range(10, 60);
         pop_pattern = (phase == 2) ? 16'hffff : 16'($urandom_range(0, 65535)) | 16'h0001;
         repeat (4) queue_random_table();
         if (phase == 3) begin
            // Hold the sender just after a sector ends until its results are all out
            while (sector_stream_q.size() > 2 * SECTOR_BYTES - 3) @(negedge clock);
            send_hold = 1'b1;
            while (expected_entries.size() != 0) @(negedge clock);
            send_hold = 1'b0;
         end
         drain();
      end

      // Stop popping until the job queue backs up onto the byte stream
      write_register(CSR_SECTOR_COUNT, '1);
      write_register(CSR_SECTOR_SIZE, 48'd512);
      gap_pct = 0;
      rsp_hold = 1'b1;
      repeat (4) queue_random_table();
      while (sector_stream_q.size() != 0 && !req_full) @(negedge clock);
      rsp_hold = 1'b0;
      drain();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
